### hw/rtl/stp_pkg.sv
// Package for the segmented toy processor step block.
// Holds payload types, instruction and interrupt codes, and register offsets.
// No dependencies.
package stp_pkg;

  typedef logic signed [31:0] word_t;
  typedef logic signed [15:0] pc_t;
  typedef logic [2:0]         irq_t;
  typedef logic [1:0]         mode_t;
  typedef logic [6:0]         laddr_t;

  localparam mode_t MODE_WRITE = 2'd0;
  localparam mode_t MODE_EXEC  = 2'd1;
  localparam mode_t MODE_SETPC = 2'd2;

  localparam irq_t IRQ_NONE  = 3'd0;
  localparam irq_t IRQ_SEGV  = 3'd1;
  localparam irq_t IRQ_ILL   = 3'd2;
  localparam irq_t IRQ_SYSC  = 3'd3;
  localparam irq_t IRQ_CLOCK = 3'd4;
  localparam irq_t IRQ_HALT  = 3'd5;

  localparam logic [9:0] OP_ADD   = 10'd0;
  localparam logic [9:0] OP_SUB   = 10'd1;
  localparam logic [9:0] OP_CMP   = 10'd2;
  localparam logic [9:0] OP_IFGT  = 10'd3;
  localparam logic [9:0] OP_NOP   = 10'd4;
  localparam logic [9:0] OP_JUMP  = 10'd5;
  localparam logic [9:0] OP_HALT  = 10'd6;
  localparam logic [9:0] OP_SYSC  = 10'd7;
  localparam logic [9:0] OP_LOAD  = 10'd8;
  localparam logic [9:0] OP_STORE = 10'd9;

  localparam int CFG_AW = 4;
  localparam logic [1:0] REG_SEG_BASE    = 2'd0;
  localparam logic [1:0] REG_SEG_SIZE    = 2'd1;
  localparam logic [1:0] REG_TICK_PERIOD = 2'd2;

endpackage

### hw/rtl/stp_in_if.sv
// Input channel of the segmented toy processor step block.
// Depends on stp_pkg for the payload types.
interface stp_in_if;
  import stp_pkg::*;
  logic   valid;
  logic   ready;
  mode_t  mode;
  laddr_t load_address;
  word_t  load_word;
  pc_t    start_pc;
  modport source (output valid, output mode, output load_address, output load_word,
                  output start_pc, input ready);
  modport sink (input valid, input mode, input load_address, input load_word,
                input start_pc, output ready);
endinterface

### hw/rtl/stp_out_if.sv
// Result channel of the segmented toy processor step block.
// Depends on stp_pkg for the payload types.
interface stp_out_if;
  import stp_pkg::*;
  logic  valid;
  logic  ready;
  irq_t  interrupt;
  pc_t   pc_out;
  word_t acc_out;
  logic  halted;
  modport source (output valid, output interrupt, output pc_out, output acc_out,
                  output halted, input ready);
  modport sink (input valid, input interrupt, input pc_out, input acc_out,
                input halted, output ready);
endinterface

### hw/rtl/segmented_toy_cpu_step_top.sv
// Top level of the segmented toy processor step block.
// Depends on stp_pkg, stp_in_if and stp_out_if.
// A memory write, a program counter write, an unused mode and any beat that arrives after HALT
// complete from the idle state. An executed instruction passes through fetch from the word
// memory, read of the data register file and execute, and LOAD adds its data read on the
// single word-memory port; a program counter outside the segment faults without a fetch.
// A one-beat input buffer takes the next beat while the current one executes. A single
// result register holds the finished beat, and a step completes only when that register is
// empty or is being read in the same cycle, so a stalled result holds the block. Configuration
// lies at byte offsets 0 (segment base), 4 (segment size) and 8 (tick period); write it only
// idle.
module segmented_toy_cpu_step_top #(
  parameter int MEM_WORDS     = 128,
  parameter int NUM_DATA_REGS = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  stp_in_if.sink                    in_bus,
  stp_out_if.source                 out_bus,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [stp_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import stp_pkg::*;

  localparam int AW = $clog2(MEM_WORDS);
  localparam int RW = $clog2(NUM_DATA_REGS);
  localparam int PW = (AW + 1 > 9) ? AW + 1 : 9;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_FETCH  = 2'd1;
  localparam logic [1:0] S_EXEC   = 2'd2;
  localparam logic [1:0] S_LDWAIT = 2'd3;

  function automatic logic [PW:0] seg_xlate(input logic [31:0] off,
                                            input logic [6:0] base,
                                            input logic [7:0] size);
    logic [PW-1:0] p;
    logic          ok;
    p  = PW'(base) + PW'(off[7:0]);
    ok = !off[31] && (off < {24'b0, size}) && (p < PW'(MEM_WORDS));
    return {ok, p};
  endfunction

  logic [6:0]  base_r;
  logic [7:0]  size_r;
  logic [3:0]  period_r;

  logic        ib_valid_r;
  mode_t       ib_mode_r;
  laddr_t      ib_addr_r;
  logic [31:0] ib_word_r;
  logic [15:0] ib_spc_r;

  logic [1:0]  st_r, st_nxt;
  logic [31:0] instr_r;
  logic [15:0] pc_r, pc_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [3:0]  tick_r, tick_nxt;
  logic        halt_r, halt_nxt;

  logic        out_valid_r;
  irq_t        out_irq_r;
  logic [15:0] out_pc_r;
  logic [31:0] out_acc_r;
  logic        out_halted_r;

  logic [31:0] mem [MEM_WORDS];
  logic [31:0] mem_rdata_r;
  logic        mem_re, mem_we;
  logic [AW-1:0] mem_addr;
  logic [31:0] mem_wdata;

  logic [31:0] rf_mem [NUM_DATA_REGS];
  logic [NUM_DATA_REGS-1:0] rf_valid_r;
  logic [31:0] rd_i_r, rd_j_r;
  logic        rd_i_ok_r, rd_j_ok_r;
  logic        rf_re, rf_we;
  logic [2:0]  rf_ia, rf_ja, rf_widx;
  logic [31:0] rf_wdata;

  logic        fin, pop, counted, out_free, in_ready;
  irq_t        irq;
  logic [PW:0] pc_x, d_x;
  logic [9:0]  op;
  logic [2:0]  ri;
  logic [31:0] arg_x, vi, vj, sum, add_res, sub_res;
  logic [15:0] pc_inc;
  logic [3:0]  tick_inc;
  logic        cfg_wr;

  assign out_free = !out_valid_r || out_bus.ready;
  assign in_ready = !ib_valid_r || pop;
  assign in_bus.ready = in_ready;

  assign out_bus.valid     = out_valid_r;
  assign out_bus.interrupt = out_irq_r;
  assign out_bus.pc_out    = out_pc_r;
  assign out_bus.acc_out   = out_acc_r;
  assign out_bus.halted    = out_halted_r;

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    case (paddr[3:2])
      REG_SEG_BASE:    prdata = {25'b0, base_r};
      REG_SEG_SIZE:    prdata = {24'b0, size_r};
      REG_TICK_PERIOD: prdata = {28'b0, period_r};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= '0;
      size_r   <= 8'd128;
      period_r <= 4'd3;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_SEG_BASE:    base_r   <= pwdata[6:0];
        REG_SEG_SIZE:    size_r   <= pwdata[7:0];
        REG_TICK_PERIOD: period_r <= pwdata[3:0];
        default:         ;
      endcase
    end
  end

  assign pc_x     = seg_xlate({{16{pc_r[15]}}, pc_r}, base_r, size_r);
  assign op       = instr_r[9:0];
  assign ri       = instr_r[12:10];
  assign arg_x    = {{16{instr_r[31]}}, instr_r[31:16]};
  assign vi       = rd_i_ok_r ? rd_i_r : 32'd0;
  assign vj       = rd_j_ok_r ? rd_j_r : 32'd0;
  assign sum      = vj + arg_x;
  assign add_res  = vi + sum;
  assign sub_res  = vi - sum;
  assign d_x      = seg_xlate(sum, base_r, size_r);
  assign pc_inc   = pc_r + 16'd1;
  assign tick_inc = tick_r + 4'd1;
  assign rf_ia    = mem_rdata_r[12:10];
  assign rf_ja    = mem_rdata_r[15:13];

  always_comb begin
    fin       = 1'b0;
    pop       = 1'b0;
    counted   = 1'b0;
    irq       = IRQ_NONE;
    st_nxt    = st_r;
    pc_nxt    = pc_r;
    acc_nxt   = acc_r;
    tick_nxt  = tick_r;
    halt_nxt  = halt_r;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = AW'(ib_addr_r);
    mem_wdata = ib_word_r;
    rf_re     = 1'b0;
    rf_we     = 1'b0;
    rf_widx   = ri;
    rf_wdata  = add_res;
    case (st_r)
      S_IDLE: begin
        if (ib_valid_r) begin
          if (halt_r) begin
            if (out_free) begin
              fin = 1'b1;
              irq = IRQ_HALT;
            end
          end else begin
            case (ib_mode_r)
              MODE_WRITE: begin
                if (out_free) begin
                  fin    = 1'b1;
                  mem_we = PW'(ib_addr_r) < PW'(MEM_WORDS);
                end
              end
              MODE_EXEC: begin
                if (!pc_x[PW]) begin
                  if (out_free) begin
                    fin = 1'b1;
                    irq = IRQ_SEGV;
                  end
                end else begin
                  pop      = 1'b1;
                  mem_re   = 1'b1;
                  mem_addr = pc_x[AW-1:0];
                  st_nxt   = S_FETCH;
                end
              end
              MODE_SETPC: begin
                if (out_free) begin
                  fin    = 1'b1;
                  pc_nxt = ib_spc_r;
                end
              end
              default: begin
                if (out_free) begin
                  fin = 1'b1;
                end
              end
            endcase
          end
          if (fin) begin
            pop = 1'b1;
          end
        end
      end
      S_FETCH: begin
        rf_re  = 1'b1;
        st_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (op == OP_LOAD && d_x[PW]) begin
          mem_re   = 1'b1;
          mem_addr = d_x[AW-1:0];
          st_nxt   = S_LDWAIT;
        end else if (out_free) begin
          fin = 1'b1;
          case (op)
            OP_ADD: begin
              acc_nxt  = add_res;
              rf_we    = 1'b1;
              rf_wdata = add_res;
              pc_nxt   = pc_inc;
              counted  = 1'b1;
            end
            OP_SUB: begin
              acc_nxt  = sub_res;
              rf_we    = 1'b1;
              rf_wdata = sub_res;
              pc_nxt   = pc_inc;
              counted  = 1'b1;
            end
            OP_CMP: begin
              acc_nxt = sub_res;
              pc_nxt  = pc_inc;
              counted = 1'b1;
            end
            OP_IFGT: begin
              pc_nxt  = (!acc_r[31] && acc_r != 32'd0) ? arg_x[15:0] : pc_inc;
              counted = 1'b1;
            end
            OP_NOP: begin
              pc_nxt  = pc_inc;
              counted = 1'b1;
            end
            OP_JUMP: begin
              pc_nxt  = arg_x[15:0];
              counted = 1'b1;
            end
            OP_HALT: begin
              halt_nxt = 1'b1;
              irq      = IRQ_HALT;
            end
            OP_SYSC: begin
              pc_nxt = pc_inc;
              irq    = IRQ_SYSC;
            end
            OP_LOAD: begin
              acc_nxt = sum;
              irq     = IRQ_SEGV;
            end
            OP_STORE: begin
              if (!d_x[PW]) begin
                acc_nxt = sum;
                irq     = IRQ_SEGV;
              end else begin
                mem_we    = 1'b1;
                mem_addr  = d_x[AW-1:0];
                mem_wdata = vi;
                acc_nxt   = vi;
                pc_nxt    = pc_inc;
              end
            end
            default: begin
              irq = IRQ_ILL;
            end
          endcase
          if (counted) begin
            if (tick_inc >= period_r) begin
              tick_nxt = 4'd0;
              irq      = IRQ_CLOCK;
            end else begin
              tick_nxt = tick_inc;
            end
          end
          st_nxt = S_IDLE;
        end
      end
      S_LDWAIT: begin
        if (out_free) begin
          fin      = 1'b1;
          acc_nxt  = mem_rdata_r;
          rf_we    = 1'b1;
          rf_wdata = mem_rdata_r;
          pc_nxt   = pc_inc;
          st_nxt   = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      pc_r        <= '0;
      acc_r       <= '0;
      tick_r      <= '0;
      halt_r      <= 1'b0;
      ib_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      pc_r   <= pc_nxt;
      acc_r  <= acc_nxt;
      tick_r <= tick_nxt;
      halt_r <= halt_nxt;
      if (in_bus.valid && in_ready) begin
        ib_valid_r <= 1'b1;
      end else if (pop) begin
        ib_valid_r <= 1'b0;
      end
      if (fin) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_ready) begin
      ib_mode_r <= in_bus.mode;
      ib_addr_r <= in_bus.load_address;
      ib_word_r <= in_bus.load_word;
      ib_spc_r  <= in_bus.start_pc;
    end
    if (st_r == S_FETCH) begin
      instr_r <= mem_rdata_r;
    end
    if (fin) begin
      out_irq_r    <= irq;
      out_pc_r     <= pc_nxt;
      out_acc_r    <= acc_nxt;
      out_halted_r <= halt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rf_we && ({1'b0, rf_widx} < 4'(NUM_DATA_REGS))) begin
      rf_mem[rf_widx[RW-1:0]] <= rf_wdata;
    end
    if (rf_re) begin
      rd_i_r <= rf_mem[rf_ia[RW-1:0]];
      rd_j_r <= rf_mem[rf_ja[RW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_valid_r <= '0;
      rd_i_ok_r  <= 1'b0;
      rd_j_ok_r  <= 1'b0;
    end else begin
      if (rf_we && ({1'b0, rf_widx} < 4'(NUM_DATA_REGS))) begin
        rf_valid_r[rf_widx[RW-1:0]] <= 1'b1;
      end
      if (rf_re) begin
        rd_i_ok_r <= ({1'b0, rf_ia} < 4'(NUM_DATA_REGS)) && rf_valid_r[rf_ia[RW-1:0]];
        rd_j_ok_r <= ({1'b0, rf_ja} < 4'(NUM_DATA_REGS)) && rf_valid_r[rf_ja[RW-1:0]];
      end
    end
  end

  a_fetch_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_FETCH) |-> $past(mem_re))
    else $error("Instruction fetch state entered without a memory read.");

  a_single_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_re && mem_we))
    else $error("Word memory read and written in the same cycle.");

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> halt_r)
    else $error("Halted flag cleared.");

  a_halted_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_halted_r) |-> (out_irq_r == IRQ_HALT))
    else $error("Result beat while halted without the halted interrupt.");

endmodule

### sim/tb.sv
// Self-checking testbench for segmented_toy_cpu_step_top.
// Walks a directed table, random programs under several segment and tick settings
// and a HALT run, checking each result beat against fixed values or a cycle-free CPU model.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import stp_pkg::*;

  localparam int MEM_WORDS = 128;
  localparam int CYCLE_LIMIT = 400000;
  localparam mode_t MODE_UNUSED = 2'd3;
  localparam logic [9:0] OP_BAD = 10'h3FF;
  localparam logic [9:0] RUN_OPS [9] = '{OP_ADD, OP_SUB, OP_CMP, OP_IFGT, OP_NOP, OP_JUMP,
                                          OP_SYSC, OP_LOAD, OP_STORE};

  typedef struct {
    mode_t  mode;
    laddr_t addr;
    word_t  word;
    pc_t    spc;
  } step_t;

  typedef struct {
    irq_t  irq;
    pc_t   pc;
    word_t acc;
    logic  halted;
  } status_t;

  typedef struct {
    step_t   s;
    bit      fixed;
    status_t r;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  stp_in_if  in_bus ();
  stp_out_if out_bus ();

  segmented_toy_cpu_step_top DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [31:0] mem [MEM_WORDS];
  bit          mem_ok [MEM_WORDS] = '{default: 1'b0};
  logic [31:0] dreg [8] = '{default: '0};
  logic [31:0] acc = '0;
  logic [15:0] pc = '0;
  logic [3:0]  ticks = '0;
  bit          halt = 1'b0;
  logic [6:0]  seg_base = 7'd0;
  logic [7:0]  seg_size = 8'd128;
  logic [3:0]  tick_per = 4'd3;

  status_t  status_fifo [$];
  status_t  no_typed = '{IRQ_NONE, 16'sd0, 32'sd0, 1'b0};
  dir_row_t dir_tab [$];
  bit       quiet = 1'b0;
  int       mismatches = 0;
  int       phase_plan [9][5] = '{'{0, 128, 1, 100, 0}, '{0, 128, 0, 110, 1},
                                  '{0, 0, 15, 40, 0}, '{127, 128, 7, 80, 0},
                                  '{96, 32, 5, 100, 0}, '{64, 64, 15, 100, 0},
                                  '{0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0},
                                  '{0, 128, 3, 100, 0}};

  function automatic bit seg_map(input logic [31:0] off, output int phys);
    phys = 0;
    if (off[31] || off >= {24'd0, seg_size}) return 1'b0;
    phys = int'(seg_base) + int'(off);
    return phys < MEM_WORDS;
  endfunction

  function automatic irq_t run_instr();
    int          p, q;
    logic [31:0] w, arg, sum;
    logic [2:0]  ri, rj;
    bit          counted;
    if (!seg_map({{16{pc[15]}}, pc}, p)) return IRQ_SEGV;
    w = mem[p];
    ri = w[12:10];
    rj = w[15:13];
    arg = {{16{w[31]}}, w[31:16]};
    sum = dreg[rj] + arg;
    counted = 1'b1;
    case (w[9:0])
      OP_ADD: begin
        acc = dreg[ri] + sum;
        dreg[ri] = acc;
        pc = pc + 16'd1;
      end
      OP_SUB: begin
        acc = dreg[ri] - sum;
        dreg[ri] = acc;
        pc = pc + 16'd1;
      end
      OP_CMP: begin
        acc = dreg[ri] - sum;
        pc = pc + 16'd1;
      end
      OP_IFGT: begin
        if (!acc[31] && acc != 0) pc = arg[15:0];
        else pc = pc + 16'd1;
      end
      OP_NOP: pc = pc + 16'd1;
      OP_JUMP: pc = arg[15:0];
      OP_HALT: begin
        halt = 1'b1;
        return IRQ_HALT;
      end
      OP_SYSC: begin
        pc = pc + 16'd1;
        return IRQ_SYSC;
      end
      OP_LOAD: begin
        acc = sum;
        if (!seg_map(sum, q)) return IRQ_SEGV;
        acc = mem[q];
        dreg[ri] = acc;
        pc = pc + 16'd1;
        return IRQ_NONE;
      end
      OP_STORE: begin
        acc = sum;
        if (!seg_map(sum, q)) return IRQ_SEGV;
        mem[q] = dreg[ri];
        mem_ok[q] = 1'b1;
        acc = dreg[ri];
        pc = pc + 16'd1;
        return IRQ_NONE;
      end
      default: return IRQ_ILL;
    endcase
    if (counted) begin
      ticks = ticks + 4'd1;
      if (ticks >= tick_per) begin
        ticks = 4'd0;
        return IRQ_CLOCK;
      end
    end
    return IRQ_NONE;
  endfunction

  function automatic status_t cpu_step(step_t s);
    status_t r;
    irq_t    irq;
    irq = IRQ_NONE;
    if (halt) begin
      irq = IRQ_HALT;
    end else begin
      case (s.mode)
        MODE_WRITE: begin
          mem[s.addr] = s.word;
          mem_ok[s.addr] = 1'b1;
        end
        MODE_EXEC: irq = run_instr();
        MODE_SETPC: pc = s.spc;
        default: ;
      endcase
    end
    r.irq = irq;
    r.pc = pc;
    r.acc = acc;
    r.halted = halt;
    return r;
  endfunction

  // Address of a word the next instruction would read before it was ever written, or a
  // HALT it would fetch too early; -1 when the instruction is safe to run.
  function automatic int unread_word(output bit for_fetch);
    int          p, q;
    logic [31:0] w;
    for_fetch = 1'b1;
    if (halt || !seg_map({{16{pc[15]}}, pc}, p)) return -1;
    if (!mem_ok[p]) return p;
    w = mem[p];
    if (w[9:0] == OP_HALT) return p;
    if (w[9:0] == OP_LOAD && seg_map(dreg[w[15:13]] + {{16{w[31]}}, w[31:16]}, q) &&
        !mem_ok[q]) begin
      for_fetch = 1'b0;
      return q;
    end
    return -1;
  endfunction

  function automatic logic [31:0] enc(logic [9:0] op, int i, int j, int arg);
    return {arg[15:0], j[2:0], i[2:0], op};
  endfunction

  function automatic logic [31:0] rand_instr();
    logic [9:0] op;
    int         arg;
    if ($urandom_range(0, 99) < 6) op = 10'($urandom_range(0, 1023));
    else op = RUN_OPS[$urandom_range(0, 8)];
    if ($urandom_range(0, 99) < 70) arg = $urandom_range(0, seg_size == 0 ? 0 : seg_size - 1);
    else arg = $urandom_range(0, 65535);
    return enc(op, $urandom_range(0, 7), $urandom_range(0, 7), arg);
  endfunction

  function automatic step_t any_step(mode_t m);
    step_t s;
    s.mode = m;
    s.addr = 7'($urandom_range(0, MEM_WORDS - 1));
    s.word = $urandom;
    s.spc = 16'($urandom_range(0, 65535));
    return s;
  endfunction

  function automatic dir_row_t plain(mode_t m, int a, logic [31:0] w);
    dir_row_t r;
    r = '{'{m, a[6:0], w, 16'sd0}, 1'b0, '{IRQ_NONE, 16'sd0, 32'sd0, 1'b0}};
    return r;
  endfunction

  task automatic send_step(input step_t s, input bit fixed, input status_t typed);
    status_t got;
    while (!quiet && $urandom_range(0, 99) < 15) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.mode <= s.mode;
    in_bus.load_address <= s.addr;
    in_bus.load_word <= s.word;
    in_bus.start_pc <= s.spc;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    got = cpu_step(s);
    status_fifo.push_back(fixed ? typed : got);
  endtask

  task automatic put_word(int a, logic [31:0] w);
    step_t s;
    s = any_step(MODE_WRITE);
    s.addr = a[6:0];
    s.word = w;
    send_step(s, 1'b0, no_typed);
  endtask

  task automatic apb_write(logic [1:0] idx, int v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_SEG_BASE: seg_base = v[6:0];
      REG_SEG_SIZE: seg_size = v[7:0];
      REG_TICK_PERIOD: tick_per = v[3:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic retune(int b, int z, int t);
    in_bus.valid <= 1'b0;
    while (status_fifo.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    apb_write(REG_SEG_BASE, b);
    apb_write(REG_SEG_SIZE, z);
    apb_write(REG_TICK_PERIOD, t);
  endtask

  task automatic run_phase(int n_items);
    int          sent, k, o, a, pick;
    bit          fetch;
    step_t       s;
    logic [31:0] pc_off;
    sent = 0;
    k = $urandom_range(4, 12);
    for (o = 0; o < k; o++) begin
      if (o < seg_size && seg_base + o < MEM_WORDS) begin
        put_word(seg_base + o, rand_instr());
        sent++;
      end
    end
    s = any_step(MODE_SETPC);
    s.spc = 16'sd0;
    send_step(s, 1'b0, no_typed);
    sent++;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        send_step(any_step(MODE_WRITE), 1'b0, no_typed);
        sent++;
      end else if (pick < 10) begin
        send_step(any_step(MODE_UNUSED), 1'b0, no_typed);
        sent++;
      end else if (pick < 18) begin
        s = any_step(MODE_SETPC);
        if ($urandom_range(0, 99) < 70) s.spc = 16'($urandom_range(0, seg_size));
        send_step(s, 1'b0, no_typed);
        sent++;
      end else if (pick < 24) begin
        for (o = 0; o < 4; o++) begin
          pc_off = {{16{pc[15]}}, pc} + o;
          if (seg_map(pc_off, a)) begin
            put_word(a, rand_instr());
            sent++;
          end
        end
      end else begin
        a = unread_word(fetch);
        while (a >= 0) begin
          put_word(a, fetch ? rand_instr() : $urandom);
          sent++;
          a = unread_word(fetch);
        end
        send_step(any_step(MODE_EXEC), 1'b0, no_typed);
        sent++;
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : result_check
    status_t want;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_bus.valid && out_bus.ready) begin
        if (status_fifo.size() == 0) begin
          $error("result beat arrived with nothing outstanding");
          mismatches++;
        end else begin
          want = status_fifo.pop_front();
          if (out_bus.interrupt !== want.irq) begin
            $error("interrupt: expected %0d, got %0d", want.irq, out_bus.interrupt);
            mismatches++;
          end
          if (out_bus.pc_out !== want.pc) begin
            $error("pc_out: expected %0d, got %0d", want.pc, out_bus.pc_out);
            mismatches++;
          end
          if (out_bus.acc_out !== want.acc) begin
            $error("acc_out: expected %0d, got %0d", want.acc, out_bus.acc_out);
            mismatches++;
          end
          if (out_bus.halted !== want.halted) begin
            $error("halted: expected %0d, got %0d", want.halted, out_bus.halted);
            mismatches++;
          end
        end
      end
      out_bus.ready <= quiet || ($urandom_range(0, 99) >= 15);
    end
  end

  initial begin : stimulus
    int    p, i, b, z, t, n;
    step_t s;
    rst_n <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_bus.valid <= 1'b0;
    in_bus.mode <= MODE_WRITE;
    in_bus.load_address <= '0;
    in_bus.load_word <= '0;
    in_bus.start_pc <= '0;

    dir_tab.push_back('{'{MODE_SETPC, 7'd0, 32'sd0, 16'sh8000}, 1'b1,
                        '{IRQ_NONE, 16'sh8000, 32'sd0, 1'b0}});
    dir_tab.push_back('{'{MODE_EXEC, 7'd0, 32'sd0, 16'sd0}, 1'b1,
                        '{IRQ_SEGV, 16'sh8000, 32'sd0, 1'b0}});
    dir_tab.push_back('{'{MODE_UNUSED, 7'h7F, 32'hFFFF_FFFF, 16'hFFFF}, 1'b1,
                        '{IRQ_NONE, 16'sh8000, 32'sd0, 1'b0}});
    dir_tab.push_back('{'{MODE_WRITE, 7'h7F, 32'hFFFF_FFFF, 16'h7FFF}, 1'b1,
                        '{IRQ_NONE, 16'sh8000, 32'sd0, 1'b0}});
    dir_tab.push_back('{'{MODE_SETPC, 7'h7F, 32'h8000_0000, 16'sd0}, 1'b1,
                        '{IRQ_NONE, 16'sd0, 32'sd0, 1'b0}});
    dir_tab.push_back(plain(MODE_WRITE, 0, enc(OP_ADD, 1, 2, 32767)));
    dir_tab.push_back(plain(MODE_WRITE, 1, enc(OP_SUB, 1, 1, -32768)));
    dir_tab.push_back(plain(MODE_WRITE, 2, enc(OP_IFGT, 0, 0, 4)));
    dir_tab.push_back(plain(MODE_WRITE, 4, enc(OP_NOP, 0, 0, 0)));
    dir_tab.push_back(plain(MODE_WRITE, 5, enc(OP_LOAD, 3, 7, 127)));
    dir_tab.push_back(plain(MODE_WRITE, 6, enc(OP_IFGT, 0, 0, 0)));
    dir_tab.push_back(plain(MODE_WRITE, 7, enc(OP_CMP, 0, 1, 0)));
    dir_tab.push_back(plain(MODE_WRITE, 8, enc(OP_STORE, 1, 0, 126)));
    dir_tab.push_back(plain(MODE_WRITE, 9, enc(OP_JUMP, 0, 0, 11)));
    dir_tab.push_back(plain(MODE_WRITE, 11, enc(OP_SYSC, 0, 0, 0)));
    dir_tab.push_back(plain(MODE_WRITE, 12, enc(OP_BAD, 0, 0, 0)));
    for (i = 0; i < 11; i++) dir_tab.push_back(plain(MODE_EXEC, 0, 32'd0));
    dir_tab.push_back(plain(MODE_WRITE, 12, enc(OP_LOAD, 2, 3, 0)));
    dir_tab.push_back(plain(MODE_EXEC, 0, 32'd0));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    retune(0, 128, 3);
    foreach (dir_tab[i]) send_step(dir_tab[i].s, dir_tab[i].fixed, dir_tab[i].r);

    for (p = 0; p < 9; p++) begin
      if (p == 6 || p == 7) begin
        b = $urandom_range(0, 127);
        z = $urandom_range(1, 128);
        t = $urandom_range(1, 15);
        n = 100;
        quiet = 1'b0;
      end else begin
        b = phase_plan[p][0];
        z = phase_plan[p][1];
        t = phase_plan[p][2];
        n = phase_plan[p][3];
        quiet = phase_plan[p][4] != 0;
      end
      retune(b, z, t);
      run_phase(n);
    end
    quiet = 1'b0;

    s = any_step(MODE_SETPC);
    s.spc = 16'sd0;
    send_step(s, 1'b0, no_typed);
    put_word(0, enc(OP_HALT, $urandom_range(0, 7), $urandom_range(0, 7),
                    $urandom_range(0, 65535)));
    send_step(any_step(MODE_EXEC), 1'b0, no_typed);
    send_step(any_step(MODE_WRITE), 1'b0, no_typed);
    send_step(any_step(MODE_EXEC), 1'b0, no_typed);
    send_step(any_step(MODE_SETPC), 1'b0, no_typed);
    send_step(any_step(MODE_UNUSED), 1'b0, no_typed);

    in_bus.valid <= 1'b0;
    while (status_fifo.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/stp_pkg.sv
hw/rtl/stp_in_if.sv
hw/rtl/stp_out_if.sv
hw/rtl/segmented_toy_cpu_step_top.sv
sim/tb.sv
